// ===== design/tfcm_pkg.sv =====
// Shared constants, types and helper functions for the thermal false-colour mapper.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package tfcm_pkg;

    // Field widths of the pixel and result streams.
    localparam int TempW    = 16;
    localparam int RowW     = 5;
    localparam int ColW     = 5;
    localparam int ChanW    = 8;
    localparam int GainW    = 20;
    localparam int CfgDataW = 20;
    localparam int CfgIdxW  = 1;

    // Gradient position arithmetic: the product carries the stop index from bit PosShift up.
    localparam int DiffW    = TempW + 1;
    localparam int ProdW    = TempW + GainW;
    localparam int PosShift = 24;
    localparam int FracW    = 8;
    localparam int StopW    = 3;
    localparam int NumStops = 7;
    localparam int StopHiW  = ProdW - PosShift;

    // Packed stream widths, padded to whole bytes.
    localparam int InFieldW  = TempW + RowW + ColW;
    localparam int OutFieldW = 3 * ChanW + RowW + ColW;
    localparam int InDataW   = ((InFieldW + 7) / 8) * 8;
    localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

    // Sensor geometry; the row flip wraps like a 5-bit subtractor.
    localparam int Rows = 24;
    localparam logic [RowW-1:0] RowLast = RowW'(Rows - 1);

    // Register defaults after reset.
    localparam logic [TempW-1:0] RangeLowReset  = 16'hFC40;   // minus 15 degrees C
    localparam logic [GainW-1:0] RangeGainReset = 20'd11651;

    // Register indexes of the configuration channel.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_RANGE_LOW  = 1'b0,
        CFG_RANGE_GAIN = 1'b1
    } t_cfg_index;

    // Gradient position handed from the product register to the colour logic.
    typedef struct packed {
        logic             above_low;
        logic [ProdW-1:0] pos;
    } t_grad_pos;

    // Stop colours: bit 2 red, bit 1 green, bit 0 blue.
    function automatic logic [2:0] stop_rgb(input logic [StopW-1:0] idx);
        logic [2:0] rgb;
        case (idx)
            3'd0:    rgb = 3'b000;   // black
            3'd1:    rgb = 3'b001;   // blue
            3'd2:    rgb = 3'b010;   // green
            3'd3:    rgb = 3'b110;   // yellow
            3'd4:    rgb = 3'b100;   // red
            3'd5:    rgb = 3'b101;   // magenta
            3'd6:    rgb = 3'b111;   // white
            default: rgb = 3'b000;
        endcase
        return rgb;
    endfunction

    // One channel between two stops: ((c1*256 +/- f) * 255) >> 8.
    function automatic logic [ChanW-1:0] lerp_channel(
        input logic             c1,
        input logic             c2,
        input logic [FracW-1:0] frac
    );
        logic [FracW:0]     base;
        logic [2*ChanW-1:0] prod;
        case ({c1, c2})
            2'b00:   base = '0;
            2'b01:   base = {1'b0, frac};
            2'b10:   base = 9'd256 - {1'b0, frac};
            default: base = 9'd256;
        endcase
        prod = (2*ChanW)'(base) * 16'd255;
        return prod[2*ChanW-1:ChanW];
    endfunction

endpackage

// ===== design/tfcm_colour.sv =====
// Colour stage of the thermal false-colour mapper: gradient position to RGB.
// Purely combinational; depends on tfcm_pkg.
`timescale 1ns / 1ps

module tfcm_colour (
    input  tfcm_pkg::t_grad_pos             i_grad,
    output logic [tfcm_pkg::ChanW-1:0]      o_red,
    output logic [tfcm_pkg::ChanW-1:0]      o_green,
    output logic [tfcm_pkg::ChanW-1:0]      o_blue
);

    logic [tfcm_pkg::StopW-1:0] idx_lo;
    logic [tfcm_pkg::StopW-1:0] idx_hi;
    logic [tfcm_pkg::FracW-1:0] frac;
    logic [2:0]                 rgb_lo;
    logic [2:0]                 rgb_hi;
    logic                       at_top;

    // Clamp below the range to black and at the top of the range to white.
    assign at_top = i_grad.pos[tfcm_pkg::ProdW-1:tfcm_pkg::PosShift]
                    >= tfcm_pkg::StopHiW'(tfcm_pkg::NumStops - 1);

    always_comb begin
        if (!i_grad.above_low) begin
            idx_lo = '0;
            idx_hi = '0;
            frac   = '0;
        end else if (at_top) begin
            idx_lo = tfcm_pkg::StopW'(tfcm_pkg::NumStops - 1);
            idx_hi = tfcm_pkg::StopW'(tfcm_pkg::NumStops - 1);
            frac   = '0;
        end else begin
            idx_lo = i_grad.pos[tfcm_pkg::PosShift +: tfcm_pkg::StopW];
            idx_hi = idx_lo + 3'd1;
            frac   = i_grad.pos[tfcm_pkg::PosShift-1 -: tfcm_pkg::FracW];
        end
    end

    assign rgb_lo = tfcm_pkg::stop_rgb(idx_lo);
    assign rgb_hi = tfcm_pkg::stop_rgb(idx_hi);

    // Each channel interpolates on its own between the two stop colours.
    assign o_red   = tfcm_pkg::lerp_channel(rgb_lo[2], rgb_hi[2], frac);
    assign o_green = tfcm_pkg::lerp_channel(rgb_lo[1], rgb_hi[1], frac);
    assign o_blue  = tfcm_pkg::lerp_channel(rgb_lo[0], rgb_hi[0], frac);

endmodule

// ===== design/thermal_false_colour_mapper.sv =====
// Throughput: one pixel per cycle while the output is not stalled, set by the three register
// stages (input register, product register after the 16 x 20 bit multiplier, result register),
// each with its own ready.
// Reset clears all valid flags and loads range_low = -960 and range_gain = 11651.
// Configuration writes take effect on the next cycle; the configuration channel is always ready.
// Depends on tfcm_pkg and tfcm_colour.
`timescale 1ns / 1ps

module thermal_false_colour_mapper (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Pixel input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: temperature[15:0], sensor_row[20:16], sensor_col[25:21], zero padding[31:26]
    input  logic [tfcm_pkg::InDataW-1:0]      s_axis_tdata,
    // Result output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: red[7:0], green[15:8], blue[23:16], image_row[28:24], image_col[33:29],
    //        zero padding[39:34]
    output logic [tfcm_pkg::OutDataW-1:0]     m_axis_tdata,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tfcm_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [tfcm_pkg::CfgDataW-1:0]     i_cfg_data
);

    // Configuration registers
    logic [tfcm_pkg::TempW-1:0] r_range_low;
    logic [tfcm_pkg::GainW-1:0] r_range_gain;

    // Stage 1: input register
    logic                       r_v1;
    logic [tfcm_pkg::TempW-1:0] r_temp1;
    logic [tfcm_pkg::RowW-1:0]  r_row1;
    logic [tfcm_pkg::ColW-1:0]  r_col1;

    // Stage 2: product register
    logic                       r_v2;
    tfcm_pkg::t_grad_pos        r_grad2;
    logic [tfcm_pkg::RowW-1:0]  r_row2;
    logic [tfcm_pkg::ColW-1:0]  r_col2;

    // Stage 3: result register
    logic                       r_v3;
    logic [tfcm_pkg::ChanW-1:0] r_red;
    logic [tfcm_pkg::ChanW-1:0] r_green;
    logic [tfcm_pkg::ChanW-1:0] r_blue;
    logic [tfcm_pkg::RowW-1:0]  r_row3;
    logic [tfcm_pkg::ColW-1:0]  r_col3;

    logic                       rdy1;
    logic                       rdy2;
    logic                       rdy3;
    logic                       in_xfer;
    logic [tfcm_pkg::DiffW-1:0] diff;
    tfcm_pkg::t_grad_pos        n_grad2;
    logic [tfcm_pkg::ChanW-1:0] n_red;
    logic [tfcm_pkg::ChanW-1:0] n_green;
    logic [tfcm_pkg::ChanW-1:0] n_blue;

    // A stage can take a new item when it is empty or its item moves on this cycle.
    assign rdy3          = !r_v3 || m_axis_tready;
    assign rdy2          = !r_v2 || rdy3;
    assign rdy1          = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;
    assign in_xfer       = s_axis_tvalid && rdy1;
    assign o_cfg_ready   = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= tfcm_pkg::RangeLowReset;
            r_range_gain <= tfcm_pkg::RangeGainReset;
        end else if (i_cfg_valid) begin
            case (tfcm_pkg::t_cfg_index'(i_cfg_index))
                tfcm_pkg::CFG_RANGE_LOW:  r_range_low  <= i_cfg_data[tfcm_pkg::TempW-1:0];
                tfcm_pkg::CFG_RANGE_GAIN: r_range_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1 valid and payload capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_temp1 <= s_axis_tdata[tfcm_pkg::TempW-1:0];
            r_row1  <= s_axis_tdata[tfcm_pkg::TempW +: tfcm_pkg::RowW];
            r_col1  <= s_axis_tdata[tfcm_pkg::TempW + tfcm_pkg::RowW +: tfcm_pkg::ColW];
        end
    end

    // Offset by the low bound, then scale by the gain into 2^-24 stop units.
    assign diff = {r_temp1[tfcm_pkg::TempW-1], r_temp1}
                - {r_range_low[tfcm_pkg::TempW-1], r_range_low};

    always_comb begin
        n_grad2.above_low = !diff[tfcm_pkg::DiffW-1] && (diff != '0);
        n_grad2.pos       = tfcm_pkg::ProdW'(diff[tfcm_pkg::TempW-1:0])
                          * tfcm_pkg::ProdW'(r_range_gain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    // The row flip happens alongside the multiply.
    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_grad2 <= n_grad2;
            r_row2  <= tfcm_pkg::RowLast - r_row1;
            r_col2  <= r_col1;
        end
    end

    // Gradient position to colour
    tfcm_colour u_colour (
        .i_grad  (r_grad2),
        .o_red   (n_red),
        .o_green (n_green),
        .o_blue  (n_blue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_row3  <= r_row2;
            r_col3  <= r_col2;
        end
    end

    // Result stream
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {(tfcm_pkg::OutDataW - tfcm_pkg::OutFieldW)'(0),
                            r_col3, r_row3, r_blue, r_green, r_red};

endmodule

// ===== design/tfcm_checker.sv =====
// Port-level checker for the thermal false-colour mapper, bound to the top level.
// Depends on tfcm_pkg and on the port list of thermal_false_colour_mapper.
`timescale 1ns / 1ps

module tfcm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [tfcm_pkg::OutDataW-1:0]     m_axis_tdata
);

    logic [tfcm_pkg::ChanW-1:0] red;
    logic [tfcm_pkg::ChanW-1:0] green;
    logic [tfcm_pkg::ChanW-1:0] blue;

    assign red   = m_axis_tdata[0 +: tfcm_pkg::ChanW];
    assign green = m_axis_tdata[tfcm_pkg::ChanW +: tfcm_pkg::ChanW];
    assign blue  = m_axis_tdata[2*tfcm_pkg::ChanW +: tfcm_pkg::ChanW];

    // A stalled result keeps its place and its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or vanished while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // With no result held the whole pipeline can move, so input must be taken.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused while the output register is empty");

    // Adjacent stops differ in at most two channels, so one channel is always saturated.
    a_one_channel_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (red == 8'd0 || red == 8'd255 || green == 8'd0 ||
                           green == 8'd255 || blue == 8'd0 || blue == 8'd255))
        else $error("colour lies off the gradient");

endmodule

bind thermal_false_colour_mapper tfcm_checker u_tfcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the thermal false-colour mapper: directed and random pixels
// are streamed in under random flow control, and each colour result is checked against a
// behavioural prediction. Depends on tfcm_pkg and thermal_false_colour_mapper.
`timescale 1ns / 1ps

module testbench;

    // Gradient position at which a pixel saturates to white: six stops of 2^24.
    localparam longint unsigned WhitePos   = 64'd6 << 24;
    localparam int              SixStops   = 100663296;
    localparam int              GainMax    = 1048575;
    localparam int              CycleLimit = 500000;

    // Stop colours from cold to hot, bit 2 red, bit 1 green, bit 0 blue.
    localparam logic [2:0] GradientRgb [tfcm_pkg::NumStops] =
        '{3'b000, 3'b001, 3'b010, 3'b110, 3'b100, 3'b101, 3'b111};

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [4:0] image_row;
        logic [4:0] image_col;
    } t_pixel_colour;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [tfcm_pkg::InDataW-1:0]       s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [tfcm_pkg::OutDataW-1:0]      m_axis_tdata;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [tfcm_pkg::CfgIdxW-1:0]       i_cfg_index;
    logic [tfcm_pkg::CfgDataW-1:0]      i_cfg_data;

    // Testbench copy of the two range registers.
    logic [15:0]     range_low_q;
    logic [19:0]     range_gain_q;
    t_pixel_colour   expected_colours[$];
    int              error_count = 0;
    int              cycle_count = 0;
    bit              steady_send = 1'b0;
    bit              steady_take = 1'b0;

    thermal_false_colour_mapper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Random wait before the next transfer on one side, skipped during steady stretches.
    function automatic int draw_wait(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 19));
    endfunction

    // One colour channel between two stops, with the fraction in 1/256 steps.
    function automatic logic [7:0] blend_channel(
        input logic       c_from,
        input logic       c_to,
        input logic [7:0] frac
    );
        int level;
        level = int'(c_from) * 256 + (int'(c_to) - int'(c_from)) * int'(frac);
        return 8'((level * 255) >> 8);
    endfunction

    // Expected colour and output position of one pixel under the current range registers.
    function automatic t_pixel_colour map_pixel(
        input logic [15:0] temp,
        input logic [4:0]  row,
        input logic [4:0]  col
    );
        t_pixel_colour    colour;
        int               diff;
        longint unsigned  pos;
        int               lo_stop;
        int               hi_stop;
        logic [7:0]       frac;
        diff    = int'($signed(temp)) - int'($signed(range_low_q));
        lo_stop = 0;
        hi_stop = 0;
        frac    = '0;
        // Pixels at or below the low bound stay black; at or past six stops they saturate to white.
        if (diff > 0) begin
            pos = longint'(diff) * longint'(range_gain_q);
            if (pos >= WhitePos) begin
                lo_stop = tfcm_pkg::NumStops - 1;
                hi_stop = tfcm_pkg::NumStops - 1;
            end else begin
                lo_stop = int'(pos >> 24);
                hi_stop = lo_stop + 1;
                frac    = pos[23:16];
            end
        end
        colour.red       = blend_channel(GradientRgb[lo_stop][2], GradientRgb[hi_stop][2], frac);
        colour.green     = blend_channel(GradientRgb[lo_stop][1], GradientRgb[hi_stop][1], frac);
        colour.blue      = blend_channel(GradientRgb[lo_stop][0], GradientRgb[hi_stop][0], frac);
        colour.image_row = tfcm_pkg::RowLast - row;
        colour.image_col = col;
        return colour;
    endfunction

    // Sends one pixel; valid is left high so that a following pixel can go back to back.
    task automatic send_pixel(input logic [15:0] temp, input logic [4:0] row, input logic [4:0] col);
        int gap;
        gap = draw_wait(steady_send);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, col, row, temp};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        expected_colours.push_back(map_pixel(temp, row, col));
    endtask

    // Stops the pixel stream and waits until every expected result has been taken.
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_colours.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input tfcm_pkg::t_cfg_index idx, input logic [19:0] value);
        wait_until_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            tfcm_pkg::CFG_RANGE_LOW:  range_low_q  = value[15:0];
            tfcm_pkg::CFG_RANGE_GAIN: range_gain_q = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Result side: random stalls, and every transfer is checked against the oldest prediction.
    initial begin : result_checker
        int            stall;
        t_pixel_colour want;
        t_pixel_colour got;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(steady_take);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tdata[28:24], m_axis_tdata[33:29]};
            if (expected_colours.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                error_count++;
            end else begin
                want = expected_colours.pop_front();
                compare_field("red", want.red, got.red);
                compare_field("green", want.green, got.green);
                compare_field("blue", want.blue, got.blue);
                compare_field("image_row", want.image_row, got.image_row);
                compare_field("image_col", want.image_col, got.image_col);
            end
        end
    end

    // Reset range: field extremes, the low bound, each stop boundary and the white threshold.
    task automatic test_reset_defaults();
        int stop_diff;
        int gain;
        gain = int'(tfcm_pkg::RangeGainReset);
        send_pixel(16'h8000, 5'd0, 5'd0);
        send_pixel(16'h7FFF, 5'd23, 5'd31);
        send_pixel(16'(-960), 5'd24, 5'd1);
        send_pixel(16'(-959), 5'd31, 5'd30);
        for (int k = 1; k < 6; k++) begin
            stop_diff = (k * 16777216 + gain - 1) / gain;
            send_pixel(16'(-960 + stop_diff - 1), 5'(k), 5'(k * 5));
            send_pixel(16'(-960 + stop_diff), 5'(k + 10), 5'(k * 6));
        end
        send_pixel(16'(-960 + 8639), 5'd12, 5'd16);
        send_pixel(16'(-960 + 8640), 5'd27, 5'd15);
    endtask

    // Register extremes, including zero gain, with both sides running back to back.
    task automatic test_register_extremes();
        steady_send = 1'b1;
        steady_take = 1'b1;
        write_register(tfcm_pkg::CFG_RANGE_LOW, 20'h07FFF);
        write_register(tfcm_pkg::CFG_RANGE_GAIN, 20'hFFFFF);
        send_pixel(16'h7FFF, 5'd5, 5'd7);
        send_pixel(16'h8000, 5'd6, 5'd8);
        write_register(tfcm_pkg::CFG_RANGE_LOW, 20'hF8000);
        send_pixel(16'h8001, 5'd7, 5'd9);
        send_pixel(16'h8010, 5'd8, 5'd10);
        send_pixel(16'h8100, 5'd9, 5'd11);
        send_pixel(16'h7FFF, 5'd10, 5'd12);
        write_register(tfcm_pkg::CFG_RANGE_GAIN, 20'h00000);
        send_pixel(16'h7FFF, 5'd11, 5'd13);
        send_pixel(16'h0000, 5'd12, 5'd14);
        write_register(tfcm_pkg::CFG_RANGE_GAIN, 20'h00001);
        send_pixel(16'h7FFF, 5'd13, 5'd15);
        steady_send = 1'b0;
        steady_take = 1'b0;
    endtask

    // Random pixels over several range settings, most of them placed around the mapped range.
    task automatic test_random_pixels();
        int          low;
        int          gain;
        int          span;
        logic [15:0] temp;
        for (int phase = 0; phase < 6; phase++) begin
            low = int'($signed(16'($urandom)));
            case (phase)
                0: begin
                    low  = -960;
                    gain = 11651;
                end
                1: begin
                    // The whole temperature scale spread over the gradient.
                    low  = -32768;
                    gain = SixStops / 65535;
                end
                2:       gain = SixStops / int'($urandom_range(1, 255));
                3:       gain = int'($urandom_range(0, GainMax));
                default: gain = SixStops / int'($urandom_range(1, 65535));
            endcase
            if (gain > GainMax) gain = GainMax;
            span = (gain == 0) ? 65535 : SixStops / gain;
            if (span > 65535) span = 65535;
            write_register(tfcm_pkg::CFG_RANGE_LOW, {4'($urandom), 16'(low)});
            write_register(tfcm_pkg::CFG_RANGE_GAIN, 20'(gain));
            for (int n = 0; n < 250; n++) begin
                // Alternate between stretches of random idling and stretches of full rate.
                if (n % 50 == 0) begin
                    steady_send = ($urandom_range(0, 2) == 0);
                    steady_take = ($urandom_range(0, 2) == 0);
                end
                if ($urandom_range(0, 4) == 0)
                    temp = 16'($urandom);
                else
                    temp = 16'(low + int'($urandom_range(0, span + span / 4)) - span / 8);
                send_pixel(temp, 5'($urandom), 5'($urandom));
            end
        end
        steady_send = 1'b0;
        steady_take = 1'b0;
    endtask

    initial begin : test_sequence
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= tfcm_pkg::CFG_RANGE_LOW;
        i_cfg_data    <= '0;
        range_low_q  = tfcm_pkg::RangeLowReset;
        range_gain_q = tfcm_pkg::RangeGainReset;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_random_pixels();
        wait_until_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
